[hw/rtl/tmta_pkg.sv]
package tmta_pkg;

  localparam int TEMPO_ENTRIES = 16;
  localparam int IDX_W         = 4;
  localparam int LEN_W         = 5;
  localparam int FRAC_W        = 16;
  localparam int TICK_W        = 48;
  localparam int MICROS_W      = 24;
  localparam int PPQ_W         = 16;
  localparam int REM_W         = 42;
  localparam int DVD_W         = 64;
  localparam int DVS_W         = 40;
  localparam int CNT_W         = 6;

  localparam logic [MICROS_W-1:0] DEFAULT_MICROS = 24'd500000;
  localparam logic [TICK_W-1:0]   TICK_MAX       = {TICK_W{1'b1}};
  localparam logic [PPQ_W-1:0]    PPQ_RESET      = 16'd480;

  localparam logic FUNC_WRITE   = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

  localparam logic REG_PPQ     = 1'b0;
  localparam logic REG_MAP_LEN = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_WALK, S_DIV1, S_DIV2, S_CHECK, S_DIV3, S_DIV4, S_OUT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic                en;
    logic [IDX_W-1:0]    addr;
    logic [31:0]         start_tick;
    logic [MICROS_W-1:0] micros;
  } tbl_wr_t;

endpackage

[hw/rtl/tmta_ifs.sv]
interface tmta_req_if import tmta_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                func;
  logic [IDX_W-1:0]    entry_index;
  logic [31:0]         entry_start_tick;
  logic [MICROS_W-1:0] entry_micros;
  logic [TICK_W-1:0]   current_tick;
  logic [31:0]         elapsed_ms;
  modport source (output valid, func, entry_index, entry_start_tick, entry_micros,
                  current_tick, elapsed_ms, input ready);
  modport sink   (input valid, func, entry_index, entry_start_tick, entry_micros,
                  current_tick, elapsed_ms, output ready);
endinterface

interface tmta_rsp_if import tmta_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] new_tick;
  logic              was_advance;
  modport source (output valid, new_tick, was_advance, input ready);
  modport sink   (input valid, new_tick, was_advance, output ready);
endinterface

interface tmta_cfg_if import tmta_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             index;
  logic [PPQ_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/tmta_table.sv]
module tmta_table import tmta_pkg::*; (
  input  logic                clk,
  input  tbl_wr_t             wr,
  input  logic [IDX_W-1:0]    start_addr,
  input  logic [IDX_W-1:0]    micros_addr,
  output logic [31:0]         start_tick,
  output logic [MICROS_W-1:0] micros
);

  logic [31:0]         starts [TEMPO_ENTRIES];
  logic [MICROS_W-1:0] mics   [TEMPO_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      starts[wr.addr] <= wr.start_tick;
      mics[wr.addr]   <= wr.micros;
    end
  end

  assign start_tick = starts[start_addr];
  assign micros     = mics[micros_addr];

endmodule

[hw/rtl/tmta_div.sv]
module tmta_div import tmta_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] r;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   r_sh;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign r_sh = {r, dvd[DVD_W-1]};
  assign diff = r_sh - {1'b0, dvs};
  assign ge   = r_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dvs <= req.divisor;
      r   <= '0;
    end else if (busy) begin
      r   <= ge ? diff[DVS_W-1:0] : r_sh[DVS_W-1:0];
      dvd <= {dvd[DVD_W-2:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = dvd;
  assign rsp.rem  = r;

endmodule

[hw/rtl/tempo_map_tick_advancer.sv]
// Channel  Dir  Beat
// req      in   func, entry_index, entry_start_tick, entry_micros, current_tick, elapsed_ms
// rsp      out  new_tick, was_advance
// cfg      in   index (0 ppq, 1 map length), data
//
// One beat at a time. A table write or a trivial advance goes from S_IDLE straight to S_OUT.
// An advance scans up to 16 table entries in S_SCAN, then per tempo segment makes 1 to 4
// passes of the shared radix-2 divider (S_DIV1 to S_DIV4).
// rst is synchronous; the tempo table is not cleared. cfg is always ready.
// req is held off from acceptance until rsp is taken.
module tempo_map_tick_advancer import tmta_pkg::*; (
  input logic clk,
  input logic rst,
  tmta_req_if.sink   req,
  tmta_rsp_if.source rsp,
  tmta_cfg_if.sink   cfg
);

  state_t state, state_next;

  logic [PPQ_W-1:0]    ppq;
  logic [LEN_W-1:0]    map_len;
  logic [TICK_W-1:0]   tick, tick_next;
  logic [REM_W-1:0]    rem, rem_next;
  logic [IDX_W-1:0]    idx, idx_next;
  logic [IDX_W-1:0]    scan_i, scan_i_next;
  logic [MICROS_W-1:0] m_r, m_r_next;
  logic [TICK_W-1:0]   nxt, nxt_next;
  logic                last, last_next;
  logic [TICK_W-1:0]   t, t_next;
  logic [31:0]         whole, whole_next;
  logic [55:0]         q1, q1_next;
  logic [TICK_W-1:0]   out_tick, out_tick_next;
  logic                out_adv, out_adv_next;

  div_req_t dv_req;
  div_rsp_t dv_rsp;
  tbl_wr_t  tbl_wr;

  logic [IDX_W-1:0]    s_addr;
  logic [31:0]         rd_start;
  logic [MICROS_W-1:0] rd_micros;
  logic [LEN_W-1:0]    n_eff, count;
  logic                n_zero;
  logic [TICK_W-1:0]   start_fx;
  logic [MICROS_W-1:0] micros_eff;
  logic [TICK_W-1:0]   d;
  logic [TICK_W:0]     sum;
  logic [31:0]         den;

  assign n_zero     = (map_len == '0);
  assign n_eff      = (map_len > LEN_W'(TEMPO_ENTRIES)) ? LEN_W'(TEMPO_ENTRIES) : map_len;
  assign count      = n_zero ? LEN_W'(1) : n_eff;
  assign s_addr     = (state == S_SCAN) ? scan_i : idx + 1'b1;
  assign start_fx   = n_zero ? '0 : {rd_start, {FRAC_W{1'b0}}};
  assign micros_eff = (n_zero || rd_micros == '0) ? DEFAULT_MICROS : rd_micros;
  assign d          = nxt - tick;
  assign sum        = {1'b0, tick} + {1'b0, t};
  assign den        = {ppq, {FRAC_W{1'b0}}};

  assign tbl_wr.en         = (state == S_IDLE) && req.valid && (req.func == FUNC_WRITE);
  assign tbl_wr.addr       = req.entry_index;
  assign tbl_wr.start_tick = req.entry_start_tick;
  assign tbl_wr.micros     = req.entry_micros;

  tmta_table u_table (
    .clk         (clk),
    .wr          (tbl_wr),
    .start_addr  (s_addr),
    .micros_addr (idx),
    .start_tick  (rd_start),
    .micros      (rd_micros)
  );

  tmta_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dv_req),
    .rsp (dv_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ppq     <= PPQ_RESET;
      map_len <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PPQ:     ppq     <= cfg.data;
        REG_MAP_LEN: map_len <= cfg.data[LEN_W-1:0];
        default:     ;
      endcase
    end
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    tick     <= tick_next;
    rem      <= rem_next;
    idx      <= idx_next;
    scan_i   <= scan_i_next;
    m_r      <= m_r_next;
    nxt      <= nxt_next;
    last     <= last_next;
    t        <= t_next;
    whole    <= whole_next;
    q1       <= q1_next;
    out_tick <= out_tick_next;
    out_adv  <= out_adv_next;
  end

  always_comb begin
    state_next      = state;
    tick_next       = tick;
    rem_next        = rem;
    idx_next        = idx;
    scan_i_next     = scan_i;
    m_r_next        = m_r;
    nxt_next        = nxt;
    last_next       = last;
    t_next          = t;
    whole_next      = whole;
    q1_next         = q1;
    out_tick_next   = out_tick;
    out_adv_next    = out_adv;
    dv_req.start    = 1'b0;
    dv_req.dividend = '0;
    dv_req.divisor  = '0;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.func == FUNC_WRITE) begin
            out_tick_next = '0;
            out_adv_next  = 1'b0;
            state_next    = S_OUT;
          end else if (req.elapsed_ms == '0 || ppq == '0) begin
            out_tick_next = req.current_tick;
            out_adv_next  = 1'b1;
            state_next    = S_OUT;
          end else begin
            tick_next   = req.current_tick;
            rem_next    = {10'b0, req.elapsed_ms} * REM_W'(1000);
            scan_i_next = '0;
            idx_next    = '0;
            state_next  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (start_fx <= tick) begin
          idx_next = scan_i;
          if ({1'b0, scan_i} + 1'b1 >= count) state_next = S_WALK;
          else scan_i_next = scan_i + 1'b1;
        end else begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        m_r_next = micros_eff;
        if (rem == '0) begin
          out_tick_next = tick;
          out_adv_next  = 1'b1;
          state_next    = S_OUT;
        end else if ({1'b0, idx} + 1'b1 >= count || start_fx > tick) begin
          last_next       = ({1'b0, idx} + 1'b1 >= count);
          nxt_next        = start_fx;
          dv_req.start    = 1'b1;
          dv_req.dividend = DVD_W'(58'(rem) * 58'(ppq));
          dv_req.divisor  = DVS_W'(micros_eff);
          state_next      = S_DIV1;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_DIV1: begin
        if (dv_rsp.done) begin
          if (dv_rsp.quot[DVD_W-1:32] != '0) begin
            t_next     = TICK_MAX;
            state_next = S_CHECK;
          end else begin
            whole_next      = dv_rsp.quot[31:0];
            dv_req.start    = 1'b1;
            dv_req.dividend = DVD_W'({dv_rsp.rem[MICROS_W-1:0], {FRAC_W{1'b0}}});
            dv_req.divisor  = DVS_W'(m_r);
            state_next      = S_DIV2;
          end
        end
      end
      S_DIV2: begin
        if (dv_rsp.done) begin
          t_next     = {whole, dv_rsp.quot[FRAC_W-1:0]};
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (last || t < d) begin
          out_tick_next = sum[TICK_W] ? TICK_MAX : sum[TICK_W-1:0];
          out_adv_next  = 1'b1;
          state_next    = S_OUT;
        end else begin
          dv_req.start    = 1'b1;
          dv_req.dividend = DVD_W'(56'(d[TICK_W-1:FRAC_W]) * 56'(m_r));
          dv_req.divisor  = DVS_W'(ppq);
          state_next      = S_DIV3;
        end
      end
      S_DIV3: begin
        if (dv_rsp.done) begin
          q1_next         = dv_rsp.quot[55:0];
          dv_req.start    = 1'b1;
          dv_req.dividend = DVD_W'(42'({dv_rsp.rem[PPQ_W-1:0], {FRAC_W{1'b0}}})
                            + 42'(41'(d[FRAC_W-1:0]) * 41'(m_r))
                            + 42'(den) - 42'd1);
          dv_req.divisor  = DVS_W'(den);
          state_next      = S_DIV4;
        end
      end
      S_DIV4: begin
        if (dv_rsp.done) begin
          rem_next   = REM_W'(64'(rem) - (64'(q1) + dv_rsp.quot));
          tick_next  = nxt;
          idx_next   = idx + 1'b1;
          state_next = S_WALK;
        end
      end
      S_OUT: begin
        if (rsp.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = (state == S_OUT);
  assign rsp.new_tick    = out_tick;
  assign rsp.was_advance = out_adv;

  a_time_no_underflow: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV4 && dv_rsp.done) |-> ((64'(q1) + dv_rsp.quot) <= 64'(rem)))
    else $error("segment time exceeds remaining time");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    dv_rsp.done |-> (state == S_DIV1 || state == S_DIV2 ||
                     state == S_DIV3 || state == S_DIV4))
    else $error("divider finished outside a wait state");

  a_idx_in_map: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> ({1'b0, idx} < count))
    else $error("walk index beyond map");

  a_walk_has_time: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (rem != '0))
    else $error("scan started with no time");

endmodule
